[src/htc_pkg.sv]
// Shared types, constants and helper functions of the height-to-colour ramp unit.
`default_nettype none
package htc_pkg;

  localparam int GRID_BITS_DEF = 8;

  localparam int BW  = 26;
  localparam int DW  = 22;
  localparam int D2W = DW + 1;
  localparam int XW  = 31;
  localparam int QW  = 8;
  localparam int NCH = 3;

  localparam logic [1:0] MODE_CLASSIC = 2'd0;
  localparam logic [1:0] MODE_HMAP    = 2'd1;
  localparam logic [1:0] MODE_GREY    = 2'd2;
  localparam logic [1:0] MODE_VOLCANO = 2'd3;

  localparam logic REG_SHADE_MODE  = 1'b0;
  localparam logic REG_PEAK_HEIGHT = 1'b1;

  localparam logic FUNC_STORE  = 1'b0;
  localparam logic FUNC_COLOUR = 1'b1;

  localparam logic [1:0] SHADE_MODE_RST  = MODE_CLASSIC;
  localparam logic [6:0] PEAK_HEIGHT_RST = 7'd30;

  typedef struct packed {
    logic [3:0] a;
    logic [3:0] b;
  } coef_t;

  typedef struct packed {
    logic [NCH-1:0][XW-1:0] x;
    logic [D2W-1:0]         d2;
  } div_in_t;

  function automatic logic signed [BW-1:0] brk(input logic [6:0] h, input int k);
    int p;
    begin
      p = int'(h) * k * 256;
      return BW'(p);
    end
  endfunction

  function automatic coef_t cf(input int a, input int b);
    coef_t c;
    begin
      c.a = 4'(a);
      c.b = 4'(b);
      return c;
    end
  endfunction

endpackage
`default_nettype wire

[src/htc_ram.sv]
// Generic single-port synchronous RAM with registered read.
`default_nettype none
module htc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

[src/htc_front.sv]
// Segment selection, ramp factor clamping and dividend formation.
`default_nettype none
module htc_front
  import htc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [15:0] height_y,
  input  wire logic [1:0]  shade_mode,
  input  wire logic [6:0]  peak_height,
  input  wire logic        biome_rd,
  output logic             out_valid,
  output div_in_t          out_data
);

  logic                    v0, v1, v2;
  logic signed [15:0]      y0;
  logic signed [BW-1:0]    ys, lo, hi, nn, dd;
  logic                    flat;
  coef_t                   c [NCH];
  logic [DW-1:0]           n_next, d_next, n1, d1;
  coef_t                   c1 [NCH];
  div_in_t                 x_next;
  logic [9:0]              ka;
  logic signed [4:0]       diff;
  logic signed [9:0]       kb;
  logic signed [33:0]      xs;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_comb begin
    ys   = BW'($signed(y0)) * BW'(60);
    flat = 1'b0;
    lo   = '0;
    hi   = '0;
    for (int i = 0; i < NCH; i++) begin
      c[i] = cf(0, 0);
    end
    unique case (shade_mode)
      MODE_CLASSIC: begin
        if (ys < 0) begin
          flat = 1'b1;
          c[1] = cf(2, 2);
        end else if (ys < brk(peak_height, 20)) begin
          hi   = brk(peak_height, 6);
          c[0] = cf(0, 1);
          c[1] = cf(2, 7);
        end else begin
          hi   = brk(peak_height, 30);
          c[0] = cf(1, 10);
          c[1] = cf(7, 10);
          c[2] = cf(0, 10);
        end
      end
      MODE_HMAP: begin
        if (ys < 0) begin
          lo   = brk(peak_height, -30);
          c[0] = cf(0, 5);
          c[2] = cf(10, 5);
        end else begin
          hi   = brk(peak_height, 30);
          c[0] = cf(5, 10);
          c[2] = cf(10, 5);
        end
      end
      MODE_GREY: begin
        flat = 1'b1;
        c[0] = cf(5, 5);
        c[1] = cf(5, 5);
        c[2] = cf(5, 5);
      end
      default: begin
        if (ys < 0) begin
          flat = 1'b1;
          c[1] = cf(2, 2);
        end else if (ys < brk(peak_height, 30)) begin
          hi   = brk(peak_height, 6);
          c[0] = cf(0, 1);
          c[1] = cf(2, 7);
        end else if (biome_rd) begin
          if (ys < brk(peak_height, 90)) begin
            lo   = brk(peak_height, 30);
            hi   = brk(peak_height, 60);
            c[0] = cf(1, 3);
            c[1] = cf(7, 3);
            c[2] = cf(0, 3);
          end else begin
            lo   = brk(peak_height, 42);
            hi   = brk(peak_height, 120);
            c[0] = cf(3, 10);
            c[1] = cf(3, 0);
            c[2] = cf(3, 0);
          end
        end else begin
          lo   = brk(peak_height, 30);
          hi   = brk(peak_height, 60);
          c[0] = cf(1, 5);
          c[1] = cf(7, 5);
          c[2] = cf(0, 5);
        end
      end
    endcase

    nn = ys - lo;
    dd = hi - lo;
    if (flat) begin
      d_next = DW'(1);
      n_next = '0;
    end else if (dd <= 0) begin
      d_next = DW'(1);
      n_next = (nn > 0) ? DW'(1) : '0;
    end else if (nn < 0) begin
      d_next = dd[DW-1:0];
      n_next = '0;
    end else if (nn > dd) begin
      d_next = dd[DW-1:0];
      n_next = dd[DW-1:0];
    end else begin
      d_next = dd[DW-1:0];
      n_next = nn[DW-1:0];
    end
  end

  always_comb begin
    x_next.d2 = {d1, 1'b0};
    for (int i = 0; i < NCH; i++) begin
      ka   = 10'(c1[i].a) * 10'd51 + 10'd1;
      diff = $signed({1'b0, c1[i].b}) - $signed({1'b0, c1[i].a});
      kb   = 10'(diff) * 10'sd51;
      xs   = $signed({12'b0, d1}) * $signed({24'b0, ka})
           + $signed({12'b0, n1}) * 34'(kb);
      x_next.x[i] = xs[XW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (in_valid) begin
        y0 <= $signed(height_y);
      end
      n1 <= n_next;
      d1 <= d_next;
      for (int i = 0; i < NCH; i++) begin
        c1[i] <= c[i];
      end
      out_data <= x_next;
    end
  end

  assign out_valid = v2;

endmodule
`default_nettype wire

[src/htc_div.sv]
// Pipelined restoring divider, one quotient bit per stage, three colour lanes.
`default_nettype none
module htc_div
  import htc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    en,
  input  wire logic    in_valid,
  input  wire div_in_t in_data,
  output logic         out_valid,
  output logic [NCH-1:0][QW-1:0] quot
);

  logic [QW-1:0]                  vld;
  logic [NCH-1:0][XW-1:0]         rem   [QW];
  logic [NCH-1:0][QW-1:0]         q     [QW];
  logic [D2W-1:0]                 d2    [QW];
  logic [NCH-1:0][XW-1:0]         rem_n [QW];
  logic [NCH-1:0][QW-1:0]         q_n   [QW];
  logic [NCH-1:0][XW-1:0]         pr;
  logic [NCH-1:0][QW-1:0]         pq;
  logic [D2W-1:0]                 pd;
  logic [XW-1:0]                  sh;

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        pr = in_data.x;
        pq = '0;
        pd = in_data.d2;
      end else begin
        pr = rem[k-1];
        pq = q[k-1];
        pd = d2[k-1];
      end
      sh = XW'(pd) << (QW - 1 - k);
      for (int i = 0; i < NCH; i++) begin
        rem_n[k][i] = pr[i];
        q_n[k][i]   = pq[i];
        if (pr[i] >= sh) begin
          rem_n[k][i]            = pr[i] - sh;
          q_n[k][i][QW - 1 - k]  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem[k] <= rem_n[k];
        q[k]   <= q_n[k];
        d2[k]  <= (k == 0) ? in_data.d2 : d2[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign quot      = q[QW-1];

endmodule
`default_nettype wire

[src/height_to_colour_ramp_unit.sv]
// Top level of the height-to-colour ramp unit.
`default_nettype none
// Takes one transaction per cycle while s_tready is high, either a biome map store (tuser
// low) or a vertex to colour (tuser high), and returns one red/green/blue transaction per
// vertex, in order: the accepting edge captures the height and reads the biome map, the
// clamped ramp numerator, denominator and factors are then registered, then the dividends,
// and the divider pipeline yields one quotient bit per stage. A store returns nothing.
// When the output is held by tready low the whole pipeline, map read included, freezes;
// s_tready then follows m_tready. Stores take effect at once, so a vertex right after a
// store to its cell sees the new bit. Registers must be written through
// cfg_we/cfg_addr/cfg_data only while the unit is idle; the unit itself does not enforce this.
module height_to_colour_ramp_unit
  import htc_pkg::*;
#(
  parameter int GRID_BITS = GRID_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // grid_x[7:0], grid_z[15:8], height_y[31:16], biome_bit[32], zero pad [39:33]
  input  wire logic [39:0] s_tdata,
  // func[0]
  input  wire logic        s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // red[7:0], green[15:8], blue[23:16]
  output logic [23:0]      m_tdata,
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [6:0]  cfg_data
);

  localparam int AW    = 2 * GRID_BITS;
  localparam int DEPTH = 1 << AW;

  logic [1:0]              shade_mode;
  logic [6:0]              peak_height;
  logic                    en, acc;
  logic [GRID_BITS-1:0]    cx, cz;
  logic                    biome_rd;
  logic                    f_valid;
  div_in_t                 f_data;
  logic [NCH-1:0][QW-1:0]  quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      shade_mode  <= SHADE_MODE_RST;
      peak_height <= PEAK_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SHADE_MODE: shade_mode  <= cfg_data[1:0];
        default:        peak_height <= cfg_data;
      endcase
    end
  end

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign acc      = s_tvalid && en;
  assign cx       = GRID_BITS'(s_tdata[7:0]);
  assign cz       = GRID_BITS'(s_tdata[15:8]);

  htc_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .en    (en),
    .we    (acc && (s_tuser == FUNC_STORE)),
    .addr  ({cx, cz}),
    .wdata (s_tdata[32]),
    .rdata (biome_rd)
  );

  htc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (acc && (s_tuser == FUNC_COLOUR)),
    .height_y    (s_tdata[31:16]),
    .shade_mode  (shade_mode),
    .peak_height (peak_height),
    .biome_rd    (biome_rd),
    .out_valid   (f_valid),
    .out_data    (f_data)
  );

  htc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_data   (f_data),
    .out_valid (m_tvalid),
    .quot      (quot)
  );

  assign m_tdata = {quot[2], quot[1], quot[0]};

endmodule
`default_nettype wire

[src/htc_checker.sv]
// Port-level assertions for the height-to-colour ramp unit and their bind.
`default_nettype none
module htc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled result changed or vanished.");

  a_ready_free: assert property (@(posedge clk)
    !m_tvalid |-> s_tready)
    else $error("Input stalled while the output register was empty.");

  a_ready_follows: assert property (@(posedge clk)
    m_tvalid |-> (s_tready == m_tready))
    else $error("Input ready does not track output ready while a result waits.");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("Result shown right after reset.");

endmodule

bind height_to_colour_ramp_unit htc_checker u_htc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

[tb/sv/tb_height_to_colour_ramp_unit.sv]
// Self-checking testbench for the height-to-colour ramp unit.
`default_nettype none
module tb_height_to_colour_ramp_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import htc_pkg::*;

  localparam int CELLS = 65536;
  localparam int LIMIT = 3000000;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } rgb_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [39:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic cfg_we = 1'b0;
  logic cfg_addr = 1'b0;
  logic [6:0] cfg_data = '0;

  logic [1:0] mode_q = MODE_CLASSIC;
  logic [6:0] hmax_q = 7'd30;
  bit written_q [CELLS];
  bit biome_q [CELLS];
  rgb_t colour_fifo [$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int cycles = 0;
  bit timed_out = 1'b0;

  always #1 clk = ~clk;

  height_to_colour_ramp_unit dut (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  function automatic longint bp(input int k);
    return longint'(hmax_q) * 256 * k;
  endfunction

  function automatic logic [7:0] ramp_chan(input longint a, input longint b,
                                           input longint lo, input longint hi,
                                           input longint ys);
    longint n, d, num, den, v;
    n = ys - lo;
    d = hi - lo;
    if (d <= 0) begin
      d = 1;
      n = (n > 0) ? 1 : 0;
    end
    if (n < 0) n = 0;
    if (n > d) n = d;
    num = 255 * (a * d + (b - a) * n);
    den = 10 * d;
    if (num < 0) num = 0;
    v = (2 * num + den) / (2 * den);
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic rgb_t vertex_colour(input logic signed [15:0] y, input bit biome);
    rgb_t c;
    longint ys;
    c = '0;
    ys = longint'(y) * 60;
    case (mode_q)
      MODE_CLASSIC: begin
        if (ys < 0) c.g = ramp_chan(2, 2, 0, 1, 0);
        else if (ys < bp(20)) begin
          c.r = ramp_chan(0, 1, 0, bp(6), ys);
          c.g = ramp_chan(2, 7, 0, bp(6), ys);
        end else begin
          c.r = ramp_chan(1, 10, 0, bp(30), ys);
          c.g = ramp_chan(7, 10, 0, bp(30), ys);
          c.b = ramp_chan(0, 10, 0, bp(30), ys);
        end
      end
      MODE_HMAP: begin
        if (ys < 0) begin
          c.r = ramp_chan(0, 5, bp(-30), 0, ys);
          c.b = ramp_chan(10, 5, bp(-30), 0, ys);
        end else begin
          c.r = ramp_chan(5, 10, 0, bp(30), ys);
          c.b = ramp_chan(10, 5, 0, bp(30), ys);
        end
      end
      MODE_GREY: begin
        c.r = ramp_chan(5, 5, 0, 1, 0);
        c.g = c.r;
        c.b = c.r;
      end
      default: begin
        if (ys < 0) c.g = ramp_chan(2, 2, 0, 1, 0);
        else if (ys < bp(30)) begin
          c.r = ramp_chan(0, 1, 0, bp(6), ys);
          c.g = ramp_chan(2, 7, 0, bp(6), ys);
        end else if (biome) begin
          if (ys < bp(90)) begin
            c.r = ramp_chan(1, 3, bp(30), bp(60), ys);
            c.g = ramp_chan(7, 3, bp(30), bp(60), ys);
            c.b = ramp_chan(0, 3, bp(30), bp(60), ys);
          end else begin
            c.r = ramp_chan(3, 10, bp(42), bp(120), ys);
            c.g = ramp_chan(3, 0, bp(42), bp(120), ys);
            c.b = ramp_chan(3, 0, bp(42), bp(120), ys);
          end
        end else begin
          c.r = ramp_chan(1, 5, bp(30), bp(60), ys);
          c.g = ramp_chan(7, 5, bp(30), bp(60), ys);
          c.b = ramp_chan(0, 5, bp(30), bp(60), ys);
        end
      end
    endcase
    return c;
  endfunction

  // Sends one transaction and records the colour it should produce, or for a store the biome bit it writes.
  task automatic send_item(input logic fn, input logic [7:0] gx, input logic [7:0] gz,
                           input logic [15:0] y, input logic bit_in);
    int idx;
    idx = int'({gx, gz});
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= fn;
    s_tdata <= {7'd0, bit_in, y, gz, gx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (fn == FUNC_STORE) begin
      written_q[idx] = 1'b1;
      biome_q[idx] = bit_in;
    end else begin
      colour_fifo.push_back(vertex_colour(y, biome_q[idx]));
    end
    @(negedge clk);
  endtask

  task automatic colour_at(input logic [15:0] y);
    send_item(FUNC_COLOUR, 8'($urandom), 8'($urandom), y, 1'($urandom));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (colour_fifo.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SHADE_MODE) mode_q = val[1:0];
    else hmax_q = val;
  endtask

  // Heights near the breakpoints of the current maximum height, plus negative and wide random ones.
  function automatic logic [15:0] pick_height();
    int k, base;
    k = $urandom_range(9);
    case (k)
      0: return 16'($urandom);
      1: return 16'(-$urandom_range(int'(hmax_q) * 128 + 300));
      default: begin
        base = int'(hmax_q) * 256 * $urandom_range(140) / 60;
        return 16'(base + $urandom_range(6) - 3);
      end
    endcase
  endfunction

  task automatic test_directed();
    write_reg(REG_PEAK_HEIGHT, 7'd30);
    for (int m = 0; m < 3; m++) begin
      write_reg(REG_SHADE_MODE, 7'(m));
      colour_at(16'h8000);
      colour_at(16'hFFFF);
      colour_at(16'h0000);
      colour_at(16'h7FFF);
      colour_at(16'(30 * 256 / 3));
      colour_at(16'(15 * 256));
    end
    send_item(FUNC_STORE, 8'hFF, 8'h00, 16'hFFFF, 1'b1);
    send_item(FUNC_STORE, 8'h00, 8'hFF, 16'h0000, 1'b0);
    write_reg(REG_SHADE_MODE, 7'(MODE_VOLCANO));
    send_item(FUNC_COLOUR, 8'hFF, 8'h00, 16'(40 * 256), 1'b0);
    send_item(FUNC_COLOUR, 8'hFF, 8'h00, 16'(80 * 256), 1'b0);
    send_item(FUNC_COLOUR, 8'h00, 8'hFF, 16'(40 * 256), 1'b1);
    send_item(FUNC_COLOUR, 8'h00, 8'hFF, 16'hFF00, 1'b1);
    write_reg(REG_PEAK_HEIGHT, 7'd0);
    send_item(FUNC_COLOUR, 8'hFF, 8'h00, 16'h0000, 1'b0);
    send_item(FUNC_COLOUR, 8'h00, 8'hFF, 16'h0001, 1'b0);
    write_reg(REG_PEAK_HEIGHT, 7'd127);
    send_item(FUNC_COLOUR, 8'hFF, 8'h00, 16'h7FFF, 1'b0);
  endtask

  task automatic test_random(input int count);
    logic [7:0] gx, gz;
    for (int i = 0; i < count; i++) begin
      gx = 8'($urandom);
      gz = 8'($urandom);
      if ($urandom_range(3) == 0 || (mode_q == MODE_VOLCANO && !written_q[{gx, gz}]))
        send_item(FUNC_STORE, gx, gz, 16'($urandom), 1'($urandom));
      else
        send_item(FUNC_COLOUR, gx, gz, pick_height(), 1'($urandom));
    end
  endtask

  task automatic test_phases();
    logic [6:0] heights [4] = '{7'd1, 7'd127, 7'd30, 7'd0};
    int stalls [4][2] = '{'{0, 0}, '{85, 0}, '{0, 85}, '{17, 17}};
    for (int p = 0; p < 16; p++) begin
      send_idle_pct = stalls[p % 4][0];
      recv_stall_pct = stalls[p % 4][1];
      write_reg(REG_SHADE_MODE, 7'(p / 4));
      write_reg(REG_PEAK_HEIGHT, p[0] ? heights[p / 4] : 7'($urandom_range(1, 127)));
      test_random(20);
      drain();
      test_random(20);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    rgb_t got, want;
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (colour_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected colour transaction %h", got);
      end else begin
        want = colour_fifo.pop_front();
        if (got.r !== want.r || got.g !== want.g || got.b !== want.b) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Colour mismatch: expected r%0d g%0d b%0d, got r%0d g%0d b%0d",
                     want.r, want.g, want.b, got.r, got.g, got.b);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("** height_to_colour_ramp_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_phases();
    drain();
    if (mismatches == 0 && colour_fifo.size() == 0) begin
      $display("** height_to_colour_ramp_unit: PASSED **");
    end else begin
      $display("** height_to_colour_ramp_unit: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
src/htc_pkg.sv
src/htc_ram.sv
src/htc_front.sv
src/htc_div.sv
src/height_to_colour_ramp_unit.sv
src/htc_checker.sv
tb/sv/tb_height_to_colour_ramp_unit.sv
